// ===== design/lz77_hash_chain_table_macros.svh =====
// assertion macros shared by the hash chain table design
`ifndef LZ77_HASH_CHAIN_TABLE_MACROS_SVH
`define LZ77_HASH_CHAIN_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lht_pkg.sv =====
// shared types and constants for the hash chain table
package lht_pkg;

  localparam int DEF_WINDOW_SIZE   = 32768;
  localparam int DEF_HASH_WIDTH    = 15;
  localparam int DEF_MIN_MATCH_LEN = 3;

  localparam int FUNC_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 16;
  localparam int HASH_OUT_W = 15;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_HASH   = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_FOLLOW = 2'd2,
    FUNC_SLIDE  = 2'd3
  } func_e;

  typedef logic [POS_W-1:0] pos_t;

endpackage

// ===== design/lht_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read port
module lht_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lz77_hash_chain_table.sv =====
// top level of the deflate hash chain table: rolling hash, head and prev memories
// a taken request waits in the response state, then its result is registered
// a new request is taken only in idle, after the previous result is loaded
// slide: walks all max(2^HASH_WIDTH, WINDOW_SIZE) entries of both memories, one a cycle
// reset: async active low; a clearing pass over max(2^HASH_WIDTH, WINDOW_SIZE) entries
// zeroes both memories, no request is taken until it is done
module lz77_hash_chain_table
  import lht_pkg::*;
#(
  parameter int WINDOW_SIZE   = DEF_WINDOW_SIZE,
  parameter int HASH_WIDTH    = DEF_HASH_WIDTH,
  parameter int MIN_MATCH_LEN = DEF_MIN_MATCH_LEN
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [BYTE_W-1:0]     next_byte_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic [POS_W-1:0]      chain_position_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_W-1:0]      match_pos_o,
  output logic [HASH_OUT_W-1:0] hash_value_o
);

`include "lz77_hash_chain_table_macros.svh"

  // memory geometry
  localparam int HDEPTH = 1 << HASH_WIDTH;
  localparam int WDEPTH = WINDOW_SIZE;
  localparam int SDEPTH = (HDEPTH > WDEPTH) ? HDEPTH : WDEPTH;
  localparam int HAW    = HASH_WIDTH;
  localparam int WAW    = $clog2(WDEPTH);
  localparam int SAW    = $clog2(SDEPTH);
  localparam int SHIFT  = (HASH_WIDTH + MIN_MATCH_LEN - 1) / MIN_MATCH_LEN;

  localparam logic [SAW-1:0]   SLAST    = SAW'(SDEPTH - 1);
  localparam logic [SAW:0]     HDEPTH_V = (SAW + 1)'(HDEPTH);
  localparam logic [SAW:0]     WDEPTH_V = (SAW + 1)'(WDEPTH);
  localparam logic [POS_W-1:0] WIN_V    = POS_W'(WINDOW_SIZE);

  // sequencer states
  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_RESP      = 3'd2;
  localparam logic [2:0] ST_SLIDE     = 3'd3;
  localparam logic [2:0] ST_SLIDE_END = 3'd4;

  // slid value of one stored position: drops out if below the window
  function automatic logic [POS_W-1:0] slide_entry(input logic [POS_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v < WIN_V) begin
      r = '0;
    end else begin
      r = v - WIN_V;
    end
    return r;
  endfunction

  logic [2:0]            state_q, state_d;
  logic [SAW-1:0]        cnt_q, cnt_d;      // sweep read / clear address
  logic [SAW-1:0]        wa_q, wa_d;        // sweep write-back address
  logic                  pend_q, pend_d;    // sweep read data waiting to be written back
  logic [HASH_WIDTH-1:0] hash_q, hash_d;
  logic [HASH_WIDTH-1:0] hash_fold;
  func_e                 func_q, func_d;
  pos_t                  pos_q, pos_d;

  logic                  out_valid_q;
  logic [POS_W-1:0]      match_q;
  logic [HASH_OUT_W-1:0] hash_out_q;
  logic                  out_load;
  logic [POS_W-1:0]      out_match;
  logic                  out_free;
  logic                  accept;

  // head memory ports
  logic                  head_we, head_re;
  logic [HAW-1:0]        head_waddr, head_raddr;
  logic [POS_W-1:0]      head_wdata, head_rdata;

  // prev memory ports
  logic                  prev_we, prev_re;
  logic [WAW-1:0]        prev_waddr, prev_raddr;
  logic [POS_W-1:0]      prev_wdata, prev_rdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // rolling hash over the last few bytes
  assign hash_fold = (hash_q << SHIFT) ^ HASH_WIDTH'(next_byte_i);

  // the sequencer never reads and writes one memory entry in the same cycle:
  // a request reads only from idle, and its write comes in the response state; the
  // sweep reads entry i+1 while writing back entry i
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    wa_d       = wa_q;
    pend_d     = pend_q;
    hash_d     = hash_q;
    func_d     = func_q;
    pos_d      = pos_q;
    out_load   = 1'b0;
    out_match  = '0;
    head_we    = 1'b0;
    head_re    = 1'b0;
    head_waddr = '0;
    head_raddr = '0;
    head_wdata = '0;
    prev_we    = 1'b0;
    prev_re    = 1'b0;
    prev_waddr = '0;
    prev_raddr = '0;
    prev_wdata = '0;

    case (state_q)
      ST_CLEAR: begin
        // zero one entry of each memory a cycle
        head_we    = ({1'b0, cnt_q} < HDEPTH_V);
        head_waddr = cnt_q[HAW-1:0];
        prev_we    = ({1'b0, cnt_q} < WDEPTH_V);
        prev_waddr = cnt_q[WAW-1:0];
        if (cnt_q == SLAST) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          func_d = func_e'(func_i);
          pos_d  = position_i;
          case (func_e'(func_i))
            FUNC_HASH: begin
              hash_d  = hash_fold;
              state_d = ST_RESP;
            end
            FUNC_INSERT: begin
              // fetch the old head under the new hash
              hash_d     = hash_fold;
              head_re    = 1'b1;
              head_raddr = hash_fold[HAW-1:0];
              state_d    = ST_RESP;
            end
            FUNC_FOLLOW: begin
              prev_re    = 1'b1;
              prev_raddr = chain_position_i[WAW-1:0];
              state_d    = ST_RESP;
            end
            FUNC_SLIDE: begin
              cnt_d   = '0;
              pend_d  = 1'b0;
              state_d = ST_SLIDE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_RESP: begin
        // finish the request once the output register has room
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          case (func_q)
            FUNC_INSERT: begin
              out_match  = head_rdata;
              prev_we    = 1'b1;
              prev_waddr = pos_q[WAW-1:0];
              prev_wdata = head_rdata;
              head_we    = 1'b1;
              head_waddr = hash_q[HAW-1:0];
              head_wdata = pos_q;
            end
            FUNC_FOLLOW: begin
              out_match = prev_rdata;
            end
            default: begin
              out_match = '0;
            end
          endcase
        end
      end

      ST_SLIDE: begin
        // read entry cnt, write back the slid entry read in the previous cycle
        head_re    = 1'b1;
        head_raddr = cnt_q[HAW-1:0];
        prev_re    = 1'b1;
        prev_raddr = cnt_q[WAW-1:0];
        head_we    = pend_q && ({1'b0, wa_q} < HDEPTH_V);
        head_waddr = wa_q[HAW-1:0];
        head_wdata = slide_entry(head_rdata);
        prev_we    = pend_q && ({1'b0, wa_q} < WDEPTH_V);
        prev_waddr = wa_q[WAW-1:0];
        prev_wdata = slide_entry(prev_rdata);
        wa_d       = cnt_q;
        pend_d     = 1'b1;
        if (cnt_q == SLAST) begin
          cnt_d   = '0;
          state_d = ST_SLIDE_END;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_SLIDE_END: begin
        // write back the last swept entry
        head_we    = pend_q && ({1'b0, wa_q} < HDEPTH_V);
        head_waddr = wa_q[HAW-1:0];
        head_wdata = slide_entry(head_rdata);
        prev_we    = pend_q && ({1'b0, wa_q} < WDEPTH_V);
        prev_waddr = wa_q[WAW-1:0];
        prev_wdata = slide_entry(prev_rdata);
        pend_d     = 1'b0;
        state_d    = ST_RESP;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      wa_q        <= '0;
      pend_q      <= 1'b0;
      hash_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wa_q    <= wa_d;
      pend_q  <= pend_d;
      hash_q  <= hash_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    pos_q  <= pos_d;
    if (out_load) begin
      match_q    <= out_match;
      hash_out_q <= HASH_OUT_W'(hash_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign match_pos_o  = match_q;
  assign hash_value_o = hash_out_q;

  // head table: newest position for each hash
  lht_ram #(
    .DEPTH (HDEPTH),
    .WIDTH (POS_W),
    .AW    (HAW)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (head_re),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  // prev table: older position with the same hash, per window slot
  lht_ram #(
    .DEPTH (WDEPTH),
    .WIDTH (POS_W),
    .AW    (WAW)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (prev_re),
    .raddr_i (prev_raddr),
    .rdata_o (prev_rdata)
  );

  // checks on the sequencer
  `LHT_ASSERT_NOW(a_head_no_rw_clash, clk_i, rst_ni, head_we && head_re, head_waddr != head_raddr, "head ram read and write hit one entry")
  `LHT_ASSERT_NOW(a_prev_no_rw_clash, clk_i, rst_ni, prev_we && prev_re, prev_waddr != prev_raddr, "prev ram read and write hit one entry")
  `LHT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, !in_ready_o, "block idle right after a request")
  `LHT_ASSERT_NEXT(a_resp_delivers, clk_i, rst_ni, (state_q == ST_RESP) && out_free, out_valid_o, "finished request produced no result")

endmodule
